// ===== design/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the PSN check checkers.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

// ===== design/rpc_pkg.sv =====
//------------------------------------------------------------------------------
// rpc_pkg
// Shared widths, codes and control types of the receiver PSN check.
//------------------------------------------------------------------------------
package rpc_pkg;

  localparam int PSN_W      = 32;
  localparam int SIZE_W     = 16;
  localparam int IMM_W      = 32;
  localparam int ECN_W      = 2;
  localparam int TIME_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(PSN_W);

  localparam logic [CFG_IDX_W-1:0] CFG_NACK_HOLDOFF     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GO_BACK_TO_CHUNK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE       = 2'd2;

  localparam logic [CFG_DATA_W-1:0] NACK_HOLDOFF_RST = 32'd500;
  localparam logic [CFG_DATA_W-1:0] CHUNK_SIZE_RST   = 32'd4000;

  typedef enum logic [1:0] {
    ST_IN_ORDER   = 2'd0,
    ST_NACKED     = 2'd1,
    ST_DUPLICATE  = 2'd2,
    ST_SUPPRESSED = 2'd3
  } pkt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic div_fin;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_sts_t;

endpackage

// ===== design/rpc_ctrl.sv =====
//------------------------------------------------------------------------------
// rpc_ctrl
// Sequencer: input capture, evaluation, chunk rounding loop, result handoff.
//------------------------------------------------------------------------------
module rpc_ctrl import rpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.need_div) state_next = S_DIV;
        else if (out_free) state_next = S_IDLE;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_EVAL: begin
        cmd.eval     = sts.need_div || out_free;
        cmd.load_out = !sts.need_div && out_free;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.div_fin  = out_free;
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/rpc_dp.sv =====
//------------------------------------------------------------------------------
// rpc_dp
// Datapath: config registers, PSN state, classification, remainder unit,
// output register.
//------------------------------------------------------------------------------
module rpc_dp import rpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PSN_W-1:0]      seq_num,
  input  logic [SIZE_W-1:0]     pkt_len,
  input  logic                  ack_request,
  input  logic                  notify_flag,
  input  logic [IMM_W-1:0]      immediate,
  input  logic [ECN_W-1:0]      ecn_bits,
  input  logic [TIME_W-1:0]     now_time,
  output pkt_status_t           out_status,
  output logic                  out_send_ack,
  output logic                  out_send_nack,
  output logic [PSN_W-1:0]      out_ack_psn,
  output logic                  out_congestion_mark,
  output logic                  out_deliver_notif,
  output logic [IMM_W-1:0]      out_notif_imm
);

  // config
  logic [CFG_DATA_W-1:0] nack_holdoff;
  logic                  go_back_to_chunk;
  logic [PSN_W-1:0]      chunk_size;

  // connection state
  logic [PSN_W-1:0]  next_expected;
  logic [TIME_W-1:0] nack_deadline;
  logic [PSN_W-1:0]  last_nacked;

  // captured packet
  logic [PSN_W-1:0]  r_seq;
  logic [SIZE_W-1:0] r_size;
  logic              r_ack_req;
  logic              r_notify;
  logic [IMM_W-1:0]  r_imm;
  logic [ECN_W-1:0]  r_ecn;
  logic [TIME_W-1:0] r_now;

  // remainder unit
  logic [PSN_W-1:0]     div_rem;
  logic [PSN_W-1:0]     div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PSN_W:0]       trial;
  logic [PSN_W-1:0]     diff;
  logic                 fits;
  logic [PSN_W-1:0]     rem_next;

  logic              in_order, gap, dup, nack_ok, nacked, suppressed;
  logic              ack, nack, sending, deliver, cong;
  logic [PSN_W-1:0]  psn_sum, psn_after, psn_rounded;
  logic [TIME_W-1:0] deadline_new;
  pkt_status_t       st;

  assign in_order   = (r_seq == next_expected);
  assign gap        = (r_seq > next_expected);
  assign dup        = !in_order && !gap;
  assign nack_ok    = (r_now >= nack_deadline) || (last_nacked != next_expected);
  assign nacked     = gap && nack_ok;
  assign suppressed = gap && !nack_ok;

  assign psn_sum      = next_expected + {{(PSN_W-SIZE_W){1'b0}}, r_size};
  assign deadline_new = r_now + {{(TIME_W-CFG_DATA_W){1'b0}}, nack_holdoff};
  assign psn_after    = in_order ? psn_sum : next_expected;

  always_comb begin
    if (in_order)        st = ST_IN_ORDER;
    else if (nacked)     st = ST_NACKED;
    else if (suppressed) st = ST_SUPPRESSED;
    else                 st = ST_DUPLICATE;
  end

  assign ack     = r_ack_req && (in_order || dup);
  assign nack    = nacked || (r_ack_req && suppressed);
  assign sending = ack || nack;
  assign deliver = in_order && r_notify;
  assign cong    = (r_ecn != '0);

  assign sts.need_div = nacked && go_back_to_chunk && (chunk_size != '0);
  assign sts.div_last = (div_cnt == DIV_CNT_W'(PSN_W-1));

  // restoring remainder, one dividend bit per cycle
  assign trial       = {div_rem, div_q[PSN_W-1]};
  assign diff        = trial[PSN_W-1:0] - chunk_size;
  assign fits        = (trial >= {1'b0, chunk_size});
  assign rem_next    = fits ? diff : trial[PSN_W-1:0];
  assign psn_rounded = next_expected - div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      nack_holdoff     <= NACK_HOLDOFF_RST;
      go_back_to_chunk <= 1'b0;
      chunk_size       <= CHUNK_SIZE_RST;
      next_expected    <= '0;
      nack_deadline    <= '0;
      last_nacked      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_NACK_HOLDOFF:     nack_holdoff     <= cfg_data;
          CFG_GO_BACK_TO_CHUNK: go_back_to_chunk <= cfg_data[0];
          CFG_CHUNK_SIZE:       chunk_size       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (in_order) next_expected <= psn_sum;
        if (nacked) begin
          nack_deadline <= deadline_new;
          last_nacked   <= next_expected;
        end
      end
      if (cmd.div_fin) next_expected <= psn_rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_seq     <= seq_num;
      r_size    <= pkt_len;
      r_ack_req <= ack_request;
      r_notify  <= notify_flag;
      r_imm     <= immediate;
      r_ecn     <= ecn_bits;
      r_now     <= now_time;
    end
    if (cmd.eval) begin
      div_rem <= '0;
      div_q   <= next_expected;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_next;
      div_q   <= {div_q[PSN_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.load_out) begin
      if (cmd.div_fin) begin
        out_status          <= ST_NACKED;
        out_send_ack        <= 1'b0;
        out_send_nack       <= 1'b1;
        out_ack_psn         <= psn_rounded;
        out_congestion_mark <= cong;
        out_deliver_notif   <= 1'b0;
        out_notif_imm       <= '0;
      end else begin
        out_status          <= st;
        out_send_ack        <= ack;
        out_send_nack       <= nack;
        out_ack_psn         <= sending ? psn_after : '0;
        out_congestion_mark <= sending && cong;
        out_deliver_notif   <= deliver;
        out_notif_imm       <= deliver ? r_imm : '0;
      end
    end
  end

endmodule

// ===== design/rdma_receiver_psn_check.sv =====
//------------------------------------------------------------------------------
// rdma_receiver_psn_check
// Receive-side PSN check of a go-back-N reliable transport.
//------------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one packet descriptor per transfer;
// output channel (out_valid/out_stall) returns one classification result per
// packet, in order. Config registers are to be written through cfg_write/
// cfg_index/cfg_data only while the block is idle; the block itself does not
// enforce this. Timing: an accepted packet is evaluated in the EVAL state and
// its result is registered into the output register, raising out_valid; a new
// packet is accepted only after that load. A NACKed gap with chunk rounding
// first runs the remainder loop (DIV state) and a finishing FIN state.
// The output register holds one result; the next packet is accepted while it
// waits, and evaluation waits only if that register is still occupied.
// A stalled result holds its value until taken.
// Reset: config returns to holdoff 500, rounding off, chunk 4000; the expected
// PSN, NACK deadline and last NACKed PSN clear to zero; no result is pending.
//------------------------------------------------------------------------------
module rdma_receiver_psn_check import rpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PSN_W-1:0]      seq_num,
  input  logic [SIZE_W-1:0]     pkt_len,
  input  logic                  ack_request,
  input  logic                  notify_flag,
  input  logic [IMM_W-1:0]      immediate,
  input  logic [ECN_W-1:0]      ecn_bits,
  input  logic [TIME_W-1:0]     now_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  send_ack,
  output logic                  send_nack,
  output logic [PSN_W-1:0]      ack_psn,
  output logic                  congestion_mark,
  output logic                  deliver_notif,
  output logic [IMM_W-1:0]      notif_imm
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  pkt_status_t out_status;

  rpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpc_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .seq_num             (seq_num),
    .pkt_len             (pkt_len),
    .ack_request         (ack_request),
    .notify_flag         (notify_flag),
    .immediate           (immediate),
    .ecn_bits            (ecn_bits),
    .now_time            (now_time),
    .out_status          (out_status),
    .out_send_ack        (send_ack),
    .out_send_nack       (send_nack),
    .out_ack_psn         (ack_psn),
    .out_congestion_mark (congestion_mark),
    .out_deliver_notif   (deliver_notif),
    .out_notif_imm       (notif_imm)
  );

  assign status = out_status;

endmodule

// ===== design/rpc_checker.sv =====
//------------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the receiver PSN check results.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module rpc_checker import rpc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       status,
  input logic             send_ack,
  input logic             send_nack,
  input logic [PSN_W-1:0] ack_psn,
  input logic             congestion_mark,
  input logic             deliver_notif
);

  logic quiet;

  assign quiet = out_valid && !send_ack && !send_nack;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_IMPL(a_ack_nack_excl, clk, rst, out_valid, !(send_ack && send_nack))
  `ASSERT_IMPL(a_quiet_zero, clk, rst, quiet, (ack_psn == '0) && !congestion_mark)
  `ASSERT_IMPL(a_notif_in_order, clk, rst, out_valid && deliver_notif, status == ST_IN_ORDER)
  `ASSERT_IMPL(a_nacked_sends, clk, rst, out_valid && (status == ST_NACKED), send_nack)

endmodule

bind rdma_receiver_psn_check rpc_checker u_rpc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .send_ack        (send_ack),
  .send_nack       (send_nack),
  .ack_psn         (ack_psn),
  .congestion_mark (congestion_mark),
  .deliver_notif   (deliver_notif)
);
